// ===== hw/rtl/dedup_event_fifo_with_discount_defines.svh =====
// Assertion macros used by the port checker of the dedup event queue.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef DEDUP_EVENT_FIFO_WITH_DISCOUNT_DEFINES_SVH
`define DEDUP_EVENT_FIFO_WITH_DISCOUNT_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define DQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dedup queue check failed");

// next-cycle implication
`define DQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dedup queue check failed");

`endif

// ===== hw/rtl/dedupq_pkg.sv =====
// Types and constants of the dedup event queue.
// No dependencies; imported by the RTL, the checkers and the testbench.
package dedupq_pkg;

	typedef enum logic [1:0] {
		ACT_PUSH     = 2'd0,
		ACT_POP      = 2'd1,
		ACT_DISCOUNT = 2'd2,
		ACT_CLEAR    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_DUP    = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} st_t;

	typedef struct packed {
		logic [31:0]        handle;
		logic               kind;
		logic [15:0]        face;
		logic [15:0]        point;
		logic signed [31:0] ttc;
	} entry_t;

	localparam logic signed [31:0] TIME_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] TIME_MIN = 32'sh8000_0000;

endpackage

// ===== hw/rtl/dedup_event_fifo_with_discount.sv =====
// Dedup event queue: a FIFO of collision events held in one RAM, with duplicate
// drop of face-point pushes and a saturating time discount of all entries.
// Depends on dedupq_pkg and dedupq_ram.
//
// One request at a time, one result per request. A pop, a clear, an edge-edge
// push or any request on an empty queue goes from IDLE straight to FINISH.
// A face-point push and a discount walk every queued entry through the RAM's
// single read port, one entry per cycle, in the SCAN state. The discount writes
// each entry back on the write port as the walk proceeds. The queue starts empty
// at reset with no clearing pass; entries are valid only between head and head +
// fill level.
module dedup_event_fifo_with_discount
	import dedupq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic               event_kind,
	input  logic [15:0]        face_id,
	input  logic [15:0]        point_id,
	input  logic [31:0]        event_handle,
	input  logic signed [31:0] time_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        out_handle,
	output logic               out_kind,
	output logic [15:0]        out_face,
	output logic [15:0]        out_point,
	output logic signed [31:0] out_time,
	output logic               got_entry,
	output logic [1:0]         push_status,
	output logic [6:0]         fill_level,
	output logic               empty_flag
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = $bits(entry_t);

	st_t                state_q, state_d;
	action_t            op_q;
	entry_t             req_q;
	logic [CW-1:0]      count_q, count_nx;
	logic [AW-1:0]      head_q, head_nx;
	logic [AW-1:0]      tail_q, tail_nx;
	logic [CW-1:0]      issued_q;
	logic [AW-1:0]      rd_ptr_q;
	logic               v_s1;
	logic [AW-1:0]      addr_s1;
	logic               dup_q;

	logic               accept;
	logic               out_free;
	logic               issue;
	logic               full;
	logic               store;
	logic               popped;
	status_t            status;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	entry_t             ram_wdata, ram_rdata;

	entry_t             disc_entry;
	logic signed [32:0] diff;

	logic               out_valid_q;
	entry_t             out_q;
	logic               got_q;
	status_t            status_q;
	logic [6:0]         fill_q;
	logic               empty_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	dedupq_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign issue    = (state_q == S_SCAN) && (issued_q != count_q);
	assign full     = (count_q == CW'(QUEUE_DEPTH));

	// saturating subtract of the discount amount from a stored time
	always_comb begin
		diff       = {ram_rdata.ttc[31], ram_rdata.ttc} - {req_q.ttc[31], req_q.ttc};
		disc_entry = ram_rdata;
		if (diff[32] != diff[31]) begin
			disc_entry.ttc = diff[32] ? TIME_MIN : TIME_MAX;
		end else begin
			disc_entry.ttc = diff[31:0];
		end
	end

	// queue update at the end of a request
	always_comb begin
		count_nx = count_q;
		head_nx  = head_q;
		tail_nx  = tail_q;
		store    = 1'b0;
		popped   = 1'b0;
		status   = ST_STORED;
		case (op_q)
			ACT_PUSH: begin
				if (dup_q) begin
					status = ST_DUP;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					store    = 1'b1;
					tail_nx  = wrap_inc(tail_q);
					count_nx = count_q + 1'b1;
				end
			end
			ACT_POP: begin
				if (count_q != '0) begin
					popped   = 1'b1;
					head_nx  = wrap_inc(head_q);
					count_nx = count_q - 1'b1;
				end
			end
			ACT_DISCOUNT: begin
			end
			ACT_CLEAR: begin
				count_nx = '0;
				head_nx  = '0;
				tail_nx  = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = req_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ram_re = (action_t'(action) == ACT_POP);
					if (count_q != '0 &&
					    ((action_t'(action) == ACT_PUSH && !event_kind) ||
					     action_t'(action) == ACT_DISCOUNT)) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				ram_re    = issue;
				ram_raddr = rd_ptr_q;
				if (v_s1 && op_q == ACT_DISCOUNT) begin
					ram_we    = 1'b1;
					ram_waddr = addr_s1;
					ram_wdata = disc_entry;
				end
				if (!issue && !v_s1) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					ram_we  = store;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			issued_q    <= '0;
			rd_ptr_q    <= '0;
			v_s1        <= 1'b0;
			dup_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						issued_q <= '0;
						rd_ptr_q <= head_q;
						dup_q    <= 1'b0;
						v_s1     <= 1'b0;
					end
				end
				S_SCAN: begin
					v_s1 <= issue;
					if (issue) begin
						issued_q <= issued_q + 1'b1;
						rd_ptr_q <= wrap_inc(rd_ptr_q);
					end
					if (v_s1 && ram_rdata.kind == req_q.kind && ram_rdata.face == req_q.face
					    && ram_rdata.point == req_q.point) begin
						dup_q <= 1'b1;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						count_q <= count_nx;
						head_q  <= head_nx;
						tail_q  <= tail_nx;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= action_t'(action);
			req_q.handle <= event_handle;
			req_q.kind   <= event_kind;
			req_q.face   <= face_id;
			req_q.point  <= point_id;
			req_q.ttc    <= time_value;
		end
		if (state_q == S_SCAN) begin
			addr_s1 <= rd_ptr_q;
		end
		if (state_q == S_FINISH && out_free) begin
			out_q    <= popped ? ram_rdata : '0;
			got_q    <= popped;
			status_q <= status;
			fill_q   <= 7'(count_nx);
			empty_q  <= (count_nx == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_handle  = out_q.handle;
	assign out_kind    = out_q.kind;
	assign out_face    = out_q.face;
	assign out_point   = out_q.point;
	assign out_time    = out_q.ttc;
	assign got_entry   = got_q;
	assign push_status = status_q;
	assign fill_level  = fill_q;
	assign empty_flag  = empty_q;

endmodule

// ===== hw/rtl/dedupq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dedupq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/dedupq_checker.sv =====
// Port-level checks of the dedup event queue, bound to the top level.
// Depends on dedupq_pkg and dedup_event_fifo_with_discount_defines.svh.
`include "dedup_event_fifo_with_discount_defines.svh"

module dedupq_checker
	import dedupq_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [31:0]        out_handle,
	input logic signed [31:0] out_time,
	input logic               got_entry,
	input logic [1:0]         push_status,
	input logic [6:0]         fill_level,
	input logic               empty_flag
);

	`DQ_ASSERT_IMP(a_empty_fill, out_valid && empty_flag, fill_level == 7'd0)
	`DQ_ASSERT_IMP(a_pop_no_status, out_valid && got_entry, push_status == ST_STORED)
	`DQ_ASSERT_IMP(a_no_entry_zero, out_valid && !got_entry, out_handle == 32'd0 && out_time == 32'sd0)
	`DQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_handle) && $stable(fill_level))

endmodule

bind dedup_event_fifo_with_discount dedupq_checker u_dedupq_checker (.*);

// ===== test/dedup_event_fifo_with_discount_chk.sv =====
// Checker for the dedup event queue: keeps a shadow copy of the queue, predicts
// the result of every accepted request and compares it with the returned result.
// Depends on dedupq_pkg.
module dedup_event_fifo_with_discount_chk
	import dedupq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         action,
	input  logic               event_kind,
	input  logic [15:0]        face_id,
	input  logic [15:0]        point_id,
	input  logic [31:0]        event_handle,
	input  logic signed [31:0] time_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [31:0]        out_handle,
	input  logic               out_kind,
	input  logic [15:0]        out_face,
	input  logic [15:0]        out_point,
	input  logic signed [31:0] out_time,
	input  logic               got_entry,
	input  logic [1:0]         push_status,
	input  logic [6:0]         fill_level,
	input  logic               empty_flag,
	output int                 fail_count,
	output int                 open_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		entry_t     ent;
		logic       got;
		status_t    status;
		logic [6:0] fill;
		logic       empty;
	} queue_result_t;

	entry_t        shadow_entries [QUEUE_DEPTH];
	int unsigned   q_head;
	int unsigned   q_count;
	queue_result_t pending_results [$];
	queue_result_t want;
	queue_result_t seen;
	entry_t        req;

	function automatic queue_result_t next_queue_result(action_t act, entry_t item);
		queue_result_t r;
		logic          dup;
		int unsigned   slot;
		longint        diff;
		r = '0;
		r.status = ST_STORED;
		case (act)
			ACT_PUSH: begin
				dup = 1'b0;
				if (item.kind == 1'b0) begin
					for (int unsigned i = 0; i < q_count; i++) begin
						slot = (q_head + i) % QUEUE_DEPTH;
						if (shadow_entries[slot].kind == 1'b0 &&
								shadow_entries[slot].face == item.face &&
								shadow_entries[slot].point == item.point)
							dup = 1'b1;
					end
				end
				if (dup) begin
					r.status = ST_DUP;
				end else if (q_count >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_entries[(q_head + q_count) % QUEUE_DEPTH] = item;
					q_count++;
				end
			end
			ACT_POP: begin
				if (q_count > 0) begin
					r.ent = shadow_entries[q_head];
					r.got = 1'b1;
					q_head = (q_head + 1) % QUEUE_DEPTH;
					q_count--;
				end
			end
			ACT_DISCOUNT: begin
				for (int unsigned i = 0; i < q_count; i++) begin
					slot = (q_head + i) % QUEUE_DEPTH;
					diff = longint'($signed(shadow_entries[slot].ttc)) -
						longint'($signed(item.ttc));
					if (diff > longint'(TIME_MAX))
						shadow_entries[slot].ttc = TIME_MAX;
					else if (diff < longint'(TIME_MIN))
						shadow_entries[slot].ttc = TIME_MIN;
					else
						shadow_entries[slot].ttc = diff[31:0];
				end
			end
			default: begin
				q_count = 0;
				q_head = 0;
			end
		endcase
		r.fill = q_count[6:0];
		r.empty = (q_count == 0);
		return r;
	endfunction

	function automatic string fmt_result(queue_result_t r);
		return {$sformatf("handle=%h kind=%0d face=%h point=%h time=%h ",
			r.ent.handle, r.ent.kind, r.ent.face, r.ent.point, r.ent.ttc),
			$sformatf("got=%0d st=%0d fill=%0d empty=%0d",
			r.got, r.status, r.fill, r.empty)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_results.delete();
			q_head = 0;
			q_count = 0;
			fail_count = 0;
			open_results = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen.ent.handle = out_handle;
				seen.ent.kind = out_kind;
				seen.ent.face = out_face;
				seen.ent.point = out_point;
				seen.ent.ttc = out_time;
				seen.got = got_entry;
				seen.status = status_t'(push_status);
				seen.fill = fill_level;
				seen.empty = empty_flag;
				if (pending_results.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result: %s", $realtime, fmt_result(seen));
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (seen !== want) begin
						if (fail_count < 10) begin
							$display("%0t: result mismatch", $realtime);
							$display("  expected %s", fmt_result(want));
							$display("  actual   %s", fmt_result(seen));
						end
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				req.handle = event_handle;
				req.kind = event_kind;
				req.face = face_id;
				req.point = point_id;
				req.ttc = time_value;
				pending_results.insert(pending_results.size(),
					next_queue_result(action_t'(action), req));
			end
			open_results = pending_results.size();
		end
	end

endmodule

// ===== test/dedup_event_fifo_with_discount_tb.sv =====
// Testbench top of the dedup event queue: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict.
// Depends on dedupq_pkg, dedup_event_fifo_with_discount and its checker module.
module dedup_event_fifo_with_discount_tb
	import dedupq_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQUESTS = 1450;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         action;
	logic               event_kind;
	logic [15:0]        face_id;
	logic [15:0]        point_id;
	logic [31:0]        event_handle;
	logic signed [31:0] time_value;
	logic               out_valid;
	logic               out_ready;
	logic [31:0]        out_handle;
	logic               out_kind;
	logic [15:0]        out_face;
	logic [15:0]        out_point;
	logic signed [31:0] out_time;
	logic               got_entry;
	logic [1:0]         push_status;
	logic [6:0]         fill_level;
	logic               empty_flag;
	int                 fail_count;
	int                 open_results;
	int                 sent;
	int                 stall_cycles;
	bit                 steady;
	bit                 hold_req;

	dedup_event_fifo_with_discount i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.event_kind   (event_kind),
		.face_id      (face_id),
		.point_id     (point_id),
		.event_handle (event_handle),
		.time_value   (time_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_handle   (out_handle),
		.out_kind     (out_kind),
		.out_face     (out_face),
		.out_point    (out_point),
		.out_time     (out_time),
		.got_entry    (got_entry),
		.push_status  (push_status),
		.fill_level   (fill_level),
		.empty_flag   (empty_flag)
	);

	dedup_event_fifo_with_discount_chk i_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.event_kind   (event_kind),
		.face_id      (face_id),
		.point_id     (point_id),
		.event_handle (event_handle),
		.time_value   (time_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_handle   (out_handle),
		.out_kind     (out_kind),
		.out_face     (out_face),
		.out_point    (out_point),
		.out_time     (out_time),
		.got_entry    (got_entry),
		.push_status  (push_status),
		.fill_level   (fill_level),
		.empty_flag   (empty_flag),
		.fail_count   (fail_count),
		.open_results (open_results)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("dedup_event_fifo_with_discount_tb: errors");
				$finish;
			end
		end
	end

	function automatic logic [15:0] rand_key();
		if ($urandom_range(99) < 80)
			return 16'($urandom_range(3));
		return 16'($urandom);
	endfunction

	function automatic logic signed [31:0] rand_ttc();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return TIME_MAX;
		if (r < 16)
			return TIME_MIN;
		if (r < 40)
			return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
		return 32'($urandom);
	endfunction

	task automatic send_req(input action_t act, input logic kind, input logic [15:0] face,
			input logic [15:0] point, input logic [31:0] handle, input logic signed [31:0] ttc);
		steady = (sent >= 700 && sent < 900);
		while (!steady && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		event_kind <= kind;
		face_id <= face;
		point_id <= point;
		event_handle <= handle;
		time_value <= ttc;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_push(input logic kind);
		send_req(ACT_PUSH, kind, rand_key(), rand_key(), $urandom, rand_ttc());
	endtask

	task automatic send_other(input action_t act);
		send_req(act, 1'($urandom), 16'($urandom), 16'($urandom), $urandom, rand_ttc());
	endtask

	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= steady || $urandom_range(99) >= 27;
		end
	end

	initial begin
		int unsigned pick;
		int unsigned roll;
		bit          held;
		bit          paused;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_PUSH;
		event_kind = 1'b0;
		face_id = '0;
		point_id = '0;
		event_handle = '0;
		time_value = '0;
		sent = 0;
		stall_cycles = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		held = 1'b0;
		paused = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty queue corner cases
		send_req(ACT_POP, 1'b0, 16'h0, 16'h0, 32'h0, 32'sh0);
		send_req(ACT_DISCOUNT, 1'b0, 16'h0, 16'h0, 32'h0, TIME_MAX);
		send_req(ACT_CLEAR, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, TIME_MIN);
		// field extremes, duplicate drop, edge-edge never dropped
		send_req(ACT_PUSH, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, TIME_MAX);
		send_req(ACT_PUSH, 1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, TIME_MIN);
		send_req(ACT_PUSH, 1'b0, 16'h0000, 16'h0000, 32'h1234_5678, 32'sh5);
		send_req(ACT_PUSH, 1'b1, 16'h0000, 16'h0000, 32'hA5A5_5A5A, 32'sh0);
		send_req(ACT_PUSH, 1'b1, 16'h0000, 16'h0000, 32'h5A5A_A5A5, 32'sh0);
		send_req(ACT_PUSH, 1'b0, 16'h0000, 16'hFFFF, 32'h0000_0001, 32'sh1);
		// saturating discounts both ways
		send_req(ACT_DISCOUNT, 1'b0, 16'h0, 16'h0, 32'h0, -32'sd1);
		send_req(ACT_DISCOUNT, 1'b0, 16'h0, 16'h0, 32'h0, TIME_MAX);
		send_req(ACT_DISCOUNT, 1'b0, 16'h0, 16'h0, 32'h0, TIME_MIN);
		send_req(ACT_POP, 1'b0, 16'h0, 16'h0, 32'h0, 32'sh0);
		send_req(ACT_POP, 1'b0, 16'h0, 16'h0, 32'h0, 32'sh0);
		send_req(ACT_PUSH, 1'b0, 16'h0000, 16'h0000, 32'hDEAD_0001, 32'sh0001_0000);
		send_req(ACT_PUSH, 1'b0, 16'hFFFF, 16'h0000, 32'hDEAD_0002, 32'sh7FFF_0000);
		send_req(ACT_DISCOUNT, 1'b0, 16'h0, 16'h0, 32'h0, 32'sh0);
		send_req(ACT_POP, 1'b1, 16'h0, 16'h0, 32'h0, 32'sh0);
		send_req(ACT_CLEAR, 1'b0, 16'h0, 16'h0, 32'h0, 32'sh0);
		send_req(ACT_POP, 1'b0, 16'h0, 16'h0, 32'h0, 32'sh0);
		send_req(ACT_PUSH, 1'b0, 16'h0000, 16'h0000, 32'hBEEF_0000, -32'sd7);
		send_req(ACT_POP, 1'b0, 16'h0, 16'h0, 32'h0, 32'sh0);

		while (sent < RANDOM_REQUESTS + 22) begin
			if (!held && sent >= 400) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			if (!paused && sent >= 1000) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				wait (open_results == 0);
				@(negedge clk);
			end
			pick = $urandom_range(9);
			case (pick)
				0: begin
					// fill past full, with face-point keys mixed in
					repeat (76) send_push(1'($urandom_range(7) != 0));
				end
				1: begin
					// drain past empty
					repeat (72) begin
						if ($urandom_range(9) == 0)
							send_other(ACT_DISCOUNT);
						else
							send_other(ACT_POP);
					end
				end
				2: begin
					repeat (20) begin
						if ($urandom_range(9) < 6)
							send_other(ACT_DISCOUNT);
						else
							send_push(1'($urandom));
					end
				end
				default: begin
					repeat (40) begin
						roll = $urandom_range(99);
						if (roll < 45)
							send_push(1'($urandom));
						else if (roll < 80)
							send_other(ACT_POP);
						else if (roll < 95)
							send_other(ACT_DISCOUNT);
						else
							send_other(ACT_CLEAR);
					end
				end
			endcase
		end

		in_valid <= 1'b0;
		wait (open_results == 0);
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("dedup_event_fifo_with_discount_tb: clean");
		else
			$display("dedup_event_fifo_with_discount_tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dedupq_pkg.sv
hw/rtl/dedupq_ram.sv
hw/rtl/dedup_event_fifo_with_discount.sv
hw/rtl/dedupq_checker.sv
test/dedup_event_fifo_with_discount_chk.sv
test/dedup_event_fifo_with_discount_tb.sv
